### src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Width of every payload field on the ports
    localparam int FIELD_BITS = 63;

    // Exponentiation sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_DISP,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    // Request to the modular multiplier
    typedef struct packed {
        logic start;
    } t_mm_ctrl;

    // Multiplier status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

### src/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left square-and-multiply: power = base^exponent mod modulus.
// ----------------------------------------------------------------------------
// Sequence: the base is first reduced mod modulus, then each exponent bit
//   gets a modular multiply if set and a modular square unless no higher
//   bits remain; a zero exponent or modulus skips all of this.
// Throughput: one request in flight; the next is taken the cycle after the
//   result is loaded. A zero exponent gives 1, else a zero modulus gives 0.
// Reset (synchronous, active low): idle, no result pending, modulus = 1.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
    parameter int OPERAND_BITS = 63
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: modulus
    input  logic                            i_cfg_we,
    input  logic [mexp_pkg::FIELD_BITS-1:0] i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mexp_pkg::FIELD_BITS-1:0] i_base,
    input  logic [mexp_pkg::FIELD_BITS-1:0] i_exponent,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mexp_pkg::FIELD_BITS-1:0] o_power
);

    localparam int W = OPERAND_BITS;

    mexp_pkg::t_state     r_state, n_state;
    mexp_pkg::t_mm_ctrl   w_mm_ctrl;
    mexp_pkg::t_mm_status w_mm_status;

    logic [W-1:0] r_modulus;
    logic [W-1:0] r_result;
    logic [W-1:0] r_square;
    logic [W-1:0] r_exp;
    logic         r_mul_done;
    logic         r_out_valid;
    logic [mexp_pkg::FIELD_BITS-1:0] r_power;

    logic [W-1:0] w_base;
    logic [W-1:0] w_exp_in;
    logic [W-1:0] w_one_mod;    // 1 mod m
    logic [W-1:0] w_mm_x;
    logic [W-1:0] w_mm_y;
    logic [W-1:0] w_prod;
    logic         w_accept;
    logic         w_finish;     // nothing left to do in dispatch
    logic         w_do_mul;     // dispatch launches a multiply, not a square
    logic         w_out_free;

    assign w_base     = i_base[W-1:0];
    assign w_exp_in   = i_exponent[W-1:0];
    assign w_one_mod  = (r_modulus == W'(1)) ? '0 : W'(1);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Current bit still owes a multiply if set and not yet applied.
    // Done when no higher bits remain and this bit is settled; the last
    // square is never needed.
    assign w_do_mul = r_exp[0] && !r_mul_done;
    assign w_finish = ((r_exp >> 1) == '0) && !w_do_mul;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mexp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_exp_in == '0 || r_modulus == '0) begin
                        n_state = mexp_pkg::S_OUT;
                    end else begin
                        n_state = mexp_pkg::S_RED;
                    end
                end
            end
            mexp_pkg::S_RED: begin
                if (w_mm_status.done) n_state = mexp_pkg::S_DISP;
            end
            mexp_pkg::S_DISP: begin
                if (w_finish) begin
                    n_state = mexp_pkg::S_OUT;
                end else if (w_do_mul) begin
                    n_state = mexp_pkg::S_MUL;
                end else begin
                    n_state = mexp_pkg::S_SQR;
                end
            end
            mexp_pkg::S_MUL: begin
                if (w_mm_status.done) n_state = mexp_pkg::S_DISP;
            end
            mexp_pkg::S_SQR: begin
                if (w_mm_status.done) n_state = mexp_pkg::S_DISP;
            end
            mexp_pkg::S_OUT: begin
                if (w_out_free) n_state = mexp_pkg::S_IDLE;
            end
            default: n_state = mexp_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs / multiplier launch ----------------
    always_comb begin
        w_mm_ctrl.start = 1'b0;
        w_mm_x          = r_square;
        w_mm_y          = r_square;
        o_in_stall      = 1'b1;
        unique case (r_state) inside
            mexp_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                // base mod m computed as (1 mod m) * base
                w_mm_x = w_one_mod;
                w_mm_y = w_base;
                w_mm_ctrl.start = w_accept && (w_exp_in != '0) && (r_modulus != '0);
            end
            mexp_pkg::S_DISP: begin
                w_mm_ctrl.start = !w_finish;
                if (w_do_mul) w_mm_x = r_result;
            end
            mexp_pkg::S_RED, mexp_pkg::S_MUL, mexp_pkg::S_SQR, mexp_pkg::S_OUT: begin
                o_in_stall = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mm_ctrl),
        .i_x      (w_mm_x),
        .i_y      (w_mm_y),
        .i_m      (r_modulus),
        .o_status (w_mm_status),
        .o_prod   (w_prod)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_modulus <= i_cfg_data[W-1:0];
            if (r_state == mexp_pkg::S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        // datapath, no reset needed
        unique case (r_state)
            mexp_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_exp      <= w_exp_in;
                    r_mul_done <= 1'b0;
                    if (w_exp_in == '0) begin
                        r_result <= W'(1);
                    end else if (r_modulus == '0) begin
                        r_result <= '0;
                    end else begin
                        r_result <= w_one_mod;
                    end
                end
            end
            mexp_pkg::S_RED: begin
                if (w_mm_status.done) r_square <= w_prod;
            end
            mexp_pkg::S_MUL: begin
                if (w_mm_status.done) begin
                    r_result   <= w_prod;
                    r_mul_done <= 1'b1;
                end
            end
            mexp_pkg::S_SQR: begin
                if (w_mm_status.done) begin
                    r_square   <= w_prod;
                    r_exp      <= r_exp >> 1;
                    r_mul_done <= 1'b0;
                end
            end
            mexp_pkg::S_OUT: begin
                if (w_out_free) r_power <= mexp_pkg::FIELD_BITS'(r_result);
            end
            mexp_pkg::S_DISP: begin
                r_mul_done <= r_mul_done;
            end
            default: r_mul_done <= r_mul_done;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;

`ifndef NO_ASSERTIONS
    // multiplier is only launched when it is free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_ctrl.start |-> !w_mm_status.busy)
        else $error("multiplier launched while busy");

    // a launch always leaves the sequencer waiting on the multiplier
    a_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_ctrl.start |=> (r_state == mexp_pkg::S_RED || r_state == mexp_pkg::S_MUL ||
                             r_state == mexp_pkg::S_SQR) && w_mm_status.busy)
        else $error("launch without matching wait state");

    // leaving the output state always presents a result
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_OUT && w_out_free) |=> r_out_valid)
        else $error("result not presented");
`endif

endmodule

### src/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Shift-and-add modular multiplier: x*y mod m, one bit of y per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int W = 63
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mexp_pkg::t_mm_ctrl    i_ctrl,
    input  logic [W-1:0]          i_x,      // must be below m
    input  logic [W-1:0]          i_y,      // any value
    input  logic [W-1:0]          i_m,
    output mexp_pkg::t_mm_status  o_status,
    output logic [W-1:0]          o_prod
);

    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_add, n_add;
    logic [W-1:0] r_y,   n_y;
    logic         r_busy, n_busy;

    logic [W:0]   w_sum;
    logic [W:0]   w_dbl;
    logic [W:0]   w_m;
    logic         w_done;

    assign w_m    = {1'b0, i_m};
    assign w_sum  = {1'b0, r_acc} + {1'b0, r_add};
    assign w_dbl  = {r_add, 1'b0};
    assign w_done = r_busy && (r_y == '0);

    always_comb begin
        n_acc  = r_acc;
        n_add  = r_add;
        n_y    = r_y;
        n_busy = r_busy;
        if (i_ctrl.start) begin
            n_acc  = '0;
            n_add  = i_x;
            n_y    = i_y;
            n_busy = 1'b1;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            // operands stay below m, so one conditional subtract reduces
            if (r_y[0]) begin
                n_acc = (w_sum >= w_m) ? W'(w_sum - w_m) : W'(w_sum);
            end
            n_add = (w_dbl >= w_m) ? W'(w_dbl - w_m) : W'(w_dbl);
            n_y   = r_y >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_acc <= n_acc;
        r_add <= n_add;
        r_y   <= n_y;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = w_done;
    assign o_prod        = r_acc;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation_top. Requests go in on the
// valid/stall channel. An in-bench square-and-multiply model predicts each
// power, and every result is checked in order against that prediction.
// The run covers the reset modulus, zero exponents, field extremes, long
// result backpressure, random moduli and exponents, and a final steady stream.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPERAND_BITS = 63;
    localparam int FIELD_BITS   = mexp_pkg::FIELD_BITS;
    localparam int HOLD_CYCLES  = 400;     // long result hold-off
    localparam int DRAIN_CYCLES = 8400;    // one worst-case item past the last result

    typedef logic [FIELD_BITS-1:0] t_word;

    localparam t_word      WORD_MAX  = '1;
    localparam logic [63:0] OPND_MASK = (64'd1 << OPERAND_BITS) - 64'd1;

    // result-side stall behavior
    typedef enum {RX_FREE, RX_RANDOM, RX_HOLD} t_rx_mode;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT-facing signals (bench-driven ones known from time zero)
    // ------------------------------------------------------------------------
    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cfg_we    = 1'b0;
    t_word cfg_data  = '0;
    logic  req_valid = 1'b0;
    t_word req_base  = '0;
    t_word req_exp   = '0;
    logic  res_stall = 1'b0;

    logic  dut_in_stall;
    logic  dut_out_valid;
    t_word dut_power;

    // bench state
    t_word    modulus_shadow = t_word'(1);   // modulus as the block holds it
    t_word    power_q[$];                    // expected powers, oldest first
    t_rx_mode rx_mode        = RX_FREE;
    bit       req_gaps_on    = 1'b0;
    int       fail_count     = 0;
    int       checked_count  = 0;
    int       req_count      = 0;
    int       cfg_count      = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    modular_exponentiation_top #(
        .OPERAND_BITS(OPERAND_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (req_valid),
        .o_in_stall  (dut_in_stall),
        .i_base      (req_base),
        .i_exponent  (req_exp),
        .o_out_valid (dut_out_valid),
        .i_out_stall (res_stall),
        .o_power     (dut_power)
    );

    // ------------------------------------------------------------------------
    // Power predictor: right-to-left square-and-multiply, with every product
    // built by shift-and-add and reduced after each addition. All operands are
    // below the modulus, so 64-bit sums never overflow.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] shift_add_mulmod(logic [63:0] x, logic [63:0] y,
                                                     logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] addend;
        int i;
        acc    = '0;
        addend = x;
        for (i = 0; i < OPERAND_BITS && y != 0; i++) begin
            if (y[0])
                acc = (acc + addend) % m;
            addend = (addend + addend) % m;
            y = y >> 1;
        end
        return acc;
    endfunction

    function automatic t_word predict_power(t_word b, t_word e, t_word m);
        logic [63:0] bb, ee, mm, sq, acc;
        int i;
        bb = {1'b0, b} & OPND_MASK;
        ee = {1'b0, e} & OPND_MASK;
        mm = {1'b0, m} & OPND_MASK;
        // zero exponent gives 1 for any modulus, checked before the modulus
        if (ee == 0)
            return t_word'(1);
        if (mm == 0)
            return '0;
        sq  = bb % mm;
        acc = 64'd1 % mm;
        for (i = 0; i < OPERAND_BITS && ee != 0; i++) begin
            if (ee[0])
                acc = shift_add_mulmod(acc, sq, mm);
            sq = shift_add_mulmod(sq, sq, mm);
            ee = ee >> 1;
        end
        return acc[FIELD_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic t_word rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[FIELD_BITS-1:0];
    endfunction

    // Mostly short exponents keep the run short; about a third span all bits.
    function automatic t_word rand_exponent();
        int w;
        if ($urandom_range(9) == 0)
            return '0;
        w = ($urandom_range(9) < 3) ? FIELD_BITS : $urandom_range(12, 1);
        return rand_word() >> (FIELD_BITS - w);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Drives at the falling edge, samples the stall at the
    // rising edge. Valid stays high into the next request when there is no gap;
    // the prediction is queued at the edge where the request is taken.
    // ------------------------------------------------------------------------
    task automatic send_request(t_word b, t_word e);
        int gap;
        if (req_gaps_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(17, 1);
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid = 1'b1;
        req_base  = b;
        req_exp   = e;
        do @(posedge clk); while (dut_in_stall);
        power_q = {power_q, predict_power(b, e, modulus_shadow)};
        req_count++;
    endtask

    // Lower valid and wait until every queued power has come back.
    task automatic wait_idle();
        @(negedge clk);
        req_valid = 1'b0;
        while (power_q.size() != 0)
            @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_modulus(t_word value);
        @(negedge clk);
        cfg_we         = 1'b1;
        cfg_data       = value;
        modulus_shadow = value & OPND_MASK[FIELD_BITS-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result stall generator. Random mode draws stall or free bursts of random
    // length; hold mode keeps the result side stalled for the long hold-off
    // and then drops back to random mode.
    // ------------------------------------------------------------------------
    always begin : result_stall_gen
        int len;
        @(negedge clk);
        case (rx_mode)
            RX_HOLD: begin
                res_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                rx_mode = RX_RANDOM;
            end
            RX_RANDOM: begin
                len       = $urandom_range(17, 1);
                res_stall = ($urandom_range(2) == 0);
                repeat (len - 1) @(negedge clk);
            end
            default: begin
                res_stall = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker: each result taken is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : power_check
        t_word want;
        if (rst_n && dut_out_valid === 1'b1 && !res_stall) begin
            if (power_q.size() == 0) begin
                $error("power: result with no request outstanding, actual %0d", dut_power);
                fail_count++;
            end else begin
                want = power_q.pop_front();
                if (dut_power !== want) begin
                    $error("power mismatch: expected %0d, actual %0d", want, dut_power);
                    fail_count++;
                end
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Modulus left at its reset value of 1: everything is 0 except a zero
    // exponent, which still gives 1.
    task automatic test_reset_modulus();
        send_request('0, '0);
        send_request(WORD_MAX, '0);
        send_request(t_word'(5), t_word'(3));
        send_request(WORD_MAX, WORD_MAX);
        wait_idle();
    endtask

    // Zero exponent under a tiny and the largest modulus.
    task automatic test_zero_exponent();
        write_modulus(t_word'(2));
        send_request(t_word'(1), '0);
        send_request(WORD_MAX, '0);
        wait_idle();
        write_modulus(WORD_MAX);
        send_request('0, '0);
        send_request(t_word'(12345), '0);
        wait_idle();
    endtask

    // All-ones and near-extreme bases and exponents against the extreme moduli.
    task automatic test_field_extremes();
        write_modulus(WORD_MAX);
        send_request('0, WORD_MAX);
        send_request(WORD_MAX, WORD_MAX);          // base reduces to zero
        send_request(WORD_MAX - 1, WORD_MAX);
        send_request(WORD_MAX - 1, t_word'(1));
        send_request(t_word'(2), t_word'(62));
        send_request(t_word'(2), t_word'(63));     // wraps past the modulus
        send_request(t_word'(1), WORD_MAX);
        send_request(WORD_MAX - 1, t_word'(2));
        wait_idle();
        write_modulus(t_word'(1) << (FIELD_BITS - 1));
        send_request(t_word'(3), WORD_MAX);
        send_request(WORD_MAX, t_word'(1));
        wait_idle();
        write_modulus(t_word'(2));
        send_request(t_word'(3), WORD_MAX);
        send_request(t_word'(2), t_word'(5));
        wait_idle();
    endtask

    // Result side held off for a long stretch while requests keep coming, so
    // the block fills and stalls its request side. Then the sender pauses
    // until every result is back.
    task automatic test_result_backpressure();
        int i;
        write_modulus(t_word'(97));
        req_gaps_on = 1'b0;
        rx_mode     = RX_HOLD;
        for (i = 0; i < 6; i++)
            send_request(rand_word(), t_word'($urandom_range(255)));
        wait_idle();
    endtask

    // Several random moduli, small to full width, with random idling.
    task automatic test_random_moduli();
        int p, i;
        t_word m;
        t_word b;
        req_gaps_on = 1'b1;
        rx_mode     = RX_RANDOM;
        for (p = 0; p < 5; p++) begin
            case (p)
                0:       m = t_word'($urandom_range(255, 2));
                1:       m = t_word'($urandom);
                2:       m = rand_word() | (t_word'(1) << (FIELD_BITS - 1));
                3:       m = rand_word() >> $urandom_range(40, 8);
                default: m = rand_word();
            endcase
            if (m == 0)
                m = t_word'(1);
            write_modulus(m);
            for (i = 0; i < 12; i++) begin
                case ($urandom_range(7))
                    0:       b = '0;
                    1:       b = m - 1;
                    default: b = rand_word();
                endcase
                send_request(b, rand_exponent());
            end
            wait_idle();
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        int i;
        req_gaps_on = 1'b0;
        rx_mode     = RX_FREE;
        write_modulus(rand_word() | t_word'(1));
        for (i = 0; i < 20; i++)
            send_request(rand_word(), rand_exponent());
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_modulus();
        test_zero_exponent();
        test_field_extremes();
        test_result_backpressure();
        test_random_moduli();
        test_steady_stream();

        // catch any stray result after the last expected one
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d results over %0d modulus writes,",
                 req_count, checked_count, cfg_count);
        $display("with zero exponents, field extremes, long backpressure and random idling.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
